// File: rtl/pshs_pkg.sv
// Shared types, constants and the bucket hash for the pair sum hash search.
package pshs_pkg;

   localparam int DATA_W     = 32;
   localparam int BUCKETS    = 1024;               // power of two: the hash takes low bits
   localparam int MAX_ITEMS  = 4096;
   localparam int BUCKET_W   = $clog2(BUCKETS);
   localparam int SLOT_W     = $clog2(MAX_ITEMS);
   localparam int COUNT_W    = SLOT_W + 1;
   localparam int INDEX_W    = 12;
   localparam int HASH_SHIFT = 16;

   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_TARGET_SUM = 0;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SLOT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] earlier_index;
      logic [INDEX_W-1:0] later_index;
   } rsp_word_type;

   typedef struct packed {
      logic [SLOT_W-1:0] next;
      logic [DATA_W-1:0] value;
   } slot_entry_type;

   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [DATA_W-1:0] h);
      logic [DATA_W-1:0] folded;
      folded = h ^ (h >> HASH_SHIFT);
      return folded[BUCKET_W-1:0];
   endfunction

endpackage

// File: rtl/pshs_csr.sv
// APB register block holding the target sum.
module pshs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pshs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pshs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pshs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [pshs_pkg::DATA_W-1:0]       target_sum
);
   import pshs_pkg::*;

   logic [CSR_ADDR_W-1:0] reg_index;
   logic                  wr_target;
   logic [DATA_W-1:0]     target_ff;
   logic [DATA_W-1:0]     target_in;

   assign reg_index  = csr_paddr >> 2;
   assign wr_target  = csr_psel && csr_penable && csr_pwrite
                       && (reg_index == CSR_ADDR_W'(CSR_TARGET_SUM));
   assign target_in  = wr_target ? csr_pwdata[DATA_W-1:0] : target_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (reg_index == CSR_ADDR_W'(CSR_TARGET_SUM)) begin
         csr_prdata = CSR_DATA_W'(target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   assign target_sum = target_ff;

endmodule

// File: rtl/pair_sum_hash_search.sv
// Pair sum hash search top level: chained hash table walk over bucket and slot memories.
//
// Each word is one array element; the block reports the first pair of elements whose sum is
// target_sum (earlier and current position), none-found after the last element, or overflow
// once when more than 4096 elements arrive without an answer. An element that is looked up
// has its complement's bucket head read, then walks that bucket's chain, and passes a final
// state before the next acceptance; the walk reads one slot per cycle through the slot
// memory's single read port and visits at least one slot, even for an empty bucket. Elements
// that arrive after an answer, or while the table is full, skip the walk. A result waits in
// an output register and stalls the block only when the next result is ready before the
// previous one was taken. After reset the input stalls while a pass zeroes all 1024 bucket
// heads. Between arrays the tables are not cleared: a bucket head counts only when it
// points below the element count to a slot that hashes to that bucket, so the bucket
// memory is never swept between arrays.
module pair_sum_hash_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pshs_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pshs_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pshs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pshs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pshs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import pshs_pkg::*;

   logic [DATA_W-1:0]   target_sum;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                answered_ff, answered_in;
   logic                res_valid_ff, res_valid_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic                clr_busy_ff, clr_busy_in;
   logic [BUCKET_W-1:0] clr_addr_ff, clr_addr_in;

   logic [DATA_W-1:0]   value_ff, value_in;
   logic                last_ff, last_in;
   logic [DATA_W-1:0]   comp_ff, comp_in;
   logic [BUCKET_W-1:0] bucket_c_ff, bucket_c_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [COUNT_W-1:0]  bound_ff, bound_in;

   logic [SLOT_W-1:0]   head_mem [BUCKETS];
   slot_entry_type      slot_mem [MAX_ITEMS];
   logic [SLOT_W-1:0]   head_q_ff;
   slot_entry_type      slot_q_ff;

   logic                accept;
   logic                full;
   logic                link_ok;
   logic                key_hit;
   logic                chain_step;
   logic                head_rd_en;
   logic [BUCKET_W-1:0] head_rd_addr;
   logic                slot_rd_en;
   logic [SLOT_W-1:0]   slot_rd_addr;
   logic                tbl_wr_en;
   logic                fin_emit;
   logic                fin_go;
   logic                rsp_load;
   status_type          fin_status;

   pshs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .target_sum  (target_sum)
   );

   assign req_stall = (state_ff != ST_IDLE) || clr_busy_ff;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= COUNT_W'(MAX_ITEMS));
   assign comp_in   = target_sum - req_word.value;

   // post-reset pass over the bucket heads
   assign clr_addr_in = clr_busy_ff ? clr_addr_ff + BUCKET_W'(1) : clr_addr_ff;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != BUCKET_W'(BUCKETS - 1));

   // a slot belongs to the current chain only if it lies below the bound and hashes here
   assign link_ok    = ({1'b0, cur_ff} < bound_ff)
                       && (bucket_of(slot_q_ff.value) == bucket_c_ff);
   assign key_hit    = link_ok && (slot_q_ff.value == comp_ff);
   assign chain_step = link_ok && !key_hit;

   assign fin_emit   = res_valid_ff || (last_ff && !answered_ff);
   assign fin_go     = !fin_emit || !rsp_valid_ff || !rsp_stall;
   assign fin_status = res_valid_ff ? res_status_ff : STATUS_NONE;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (answered_ff || full) ? ST_FIN : ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (!chain_step) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      value_in      = value_ff;
      last_in       = last_ff;
      bucket_c_in   = bucket_c_ff;
      cur_in        = cur_ff;
      bound_in      = bound_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      count_in      = count_ff;
      answered_in   = answered_ff;
      head_rd_en    = 1'b0;
      head_rd_addr  = bucket_of(value_ff);
      slot_rd_en    = 1'b0;
      slot_rd_addr  = slot_q_ff.next;
      tbl_wr_en     = 1'b0;
      rsp_load      = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in      = req_word.value;
               last_in       = req_word.last;
               bucket_c_in   = bucket_of(comp_in);
               res_valid_in  = !answered_ff && full;
               res_status_in = STATUS_OVERFLOW;
               head_rd_en    = 1'b1;
               head_rd_addr  = bucket_of(comp_in);
            end
         end
         ST_HEAD: begin
            // start the walk and fetch the old head of the element's own bucket
            cur_in       = head_q_ff;
            bound_in     = count_ff;
            slot_rd_en   = 1'b1;
            slot_rd_addr = head_q_ff;
            head_rd_en   = 1'b1;
            head_rd_addr = bucket_of(value_ff);
         end
         ST_SLOT: begin
            if (key_hit) begin
               res_valid_in  = 1'b1;
               res_status_in = STATUS_FOUND;
            end else if (link_ok) begin
               cur_in       = slot_q_ff.next;
               bound_in     = {1'b0, cur_ff};
               slot_rd_en   = 1'b1;
               slot_rd_addr = slot_q_ff.next;
            end else begin
               tbl_wr_en = 1'b1;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               if (fin_emit) begin
                  rsp_load                  = 1'b1;
                  rsp_valid_in              = 1'b1;
                  rsp_word_in.status        = fin_status;
                  rsp_word_in.earlier_index = '0;
                  rsp_word_in.later_index   = '0;
                  if (fin_status == STATUS_FOUND) begin
                     rsp_word_in.earlier_index = INDEX_W'(cur_ff);
                     rsp_word_in.later_index   = INDEX_W'(count_ff[SLOT_W-1:0]);
                  end
               end
               if (last_ff) begin
                  count_in    = '0;
                  answered_in = 1'b0;
               end else begin
                  if (!full) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
                  answered_in = answered_ff || res_valid_ff;
               end
               res_valid_in = 1'b0;
            end
         end
         default: begin
            res_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         answered_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         answered_ff  <= answered_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      last_ff       <= last_in;
      bucket_c_ff   <= bucket_c_in;
      cur_ff        <= cur_in;
      bound_ff      <= bound_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
      if (accept) begin
         comp_ff <= comp_in;
      end
   end

   // bucket heads
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         head_mem[clr_addr_ff] <= '0;
      end else if (tbl_wr_en) begin
         head_mem[bucket_of(value_ff)] <= count_ff[SLOT_W-1:0];
      end
      if (head_rd_en) begin
         head_q_ff <= head_mem[head_rd_addr];
      end
   end

   // slots: new element goes in at the chain head, linked to the old head
   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         slot_mem[count_ff[SLOT_W-1:0]] <= '{next: head_q_ff, value: value_ff};
      end
      if (slot_rd_en) begin
         slot_q_ff <= slot_mem[slot_rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ITEMS))
      else $error("element count beyond table size");

   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (!answered_ff && !full))
      else $error("table write after answer or with table full");

   a_walk_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT && chain_step) |=> (bound_ff < $past(bound_ff)))
      else $error("chain walk bound did not shrink");

   a_found_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && fin_status == STATUS_FOUND) |-> ({1'b0, cur_ff} < count_ff))
      else $error("found pair with earlier index not below later index");

   a_array_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && fin_go && last_ff) |=> (count_ff == '0 && !answered_ff))
      else $error("table not cleared after last element");

endmodule
